// ===== design/eac_pkg.sv =====
`timescale 1ns / 1ps
// eac_pkg: field widths, register indexes, reset values and shared types
// for the excitation angle corrector. No dependencies.
package eac_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int SUM_WIDTH_DEF       = 32;

    localparam int ANGLE_W    = 17;
    localparam int ERR_W      = 17;
    localparam int OUT_W      = 32;
    localparam int GAIN_W     = 20;
    localparam int LIMIT_W    = 31;
    localparam int STEP_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int SPEED_FRAC = 8;

    localparam int IN_FIELDS_W  = 2 * ANGLE_W;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_FIELDS_W = ERR_W + OUT_W + ANGLE_W + OUT_W;
    localparam int OUT_TDATA_W  = 104;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_KI         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE     = 3'd4;

    localparam logic               INTEGRAL_ENABLE_RST = 1'b1;
    localparam logic [GAIN_W-1:0]  GAIN_KI_RST         = 20'd4096;
    localparam logic [LIMIT_W-1:0] LIMIT_START_RST     = 31'd23040;
    localparam logic [STEP_W-1:0]  LIMIT_STEP_RST      = 16'd256;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST     = 16'd256;

    typedef struct packed {
        logic grow;
        logic shrink;
    } t_bound_move;

    function automatic int deg_to_fixed(input int degrees, input int frac_bits);
        return degrees * (1 << frac_bits);
    endfunction

    function automatic int angle_calc_width(input int frac_bits);
        return (frac_bits + 11 > 19) ? frac_bits + 11 : 19;
    endfunction

endpackage

// ===== design/eac_drive.sv =====
`timescale 1ns / 1ps
// eac_drive: integral correction of the commanded angle and the bound move
// decision. Depends on eac_pkg.
module eac_drive #(
    parameter int ANGLE_FRAC_BITS = eac_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int SUM_WIDTH       = eac_pkg::SUM_WIDTH_DEF
) (
    input  logic signed [SUM_WIDTH-1:0]     i_sum,
    input  logic [eac_pkg::ANGLE_W-1:0]     i_sensor_angle,
    input  logic [eac_pkg::ANGLE_W-1:0]     i_command_angle,
    input  logic [eac_pkg::GAIN_W-1:0]      i_gain_ki,
    input  logic                            i_integral_enable,
    output logic [eac_pkg::ANGLE_W-1:0]     o_drive_angle,
    output eac_pkg::t_bound_move            o_bound_move
);

    localparam int AW       = eac_pkg::angle_calc_width(ANGLE_FRAC_BITS);
    localparam int SAT_BITS = AW;
    localparam int DW       = AW + 3;
    localparam int MB       = AW + eac_pkg::GAIN_FRAC;
    localparam int MAG_W    = (SUM_WIDTH > MB) ? SUM_WIDTH : MB;
    localparam int PROD_W   = MB + eac_pkg::GAIN_W;
    localparam int RND_W    = PROD_W - eac_pkg::GAIN_FRAC;

    localparam logic signed [DW-1:0] DEG90  = DW'(eac_pkg::deg_to_fixed(90, ANGLE_FRAC_BITS));
    localparam logic signed [DW-1:0] DEG180 = DW'(eac_pkg::deg_to_fixed(180, ANGLE_FRAC_BITS));
    localparam logic signed [DW-1:0] DEG360 = DW'(eac_pkg::deg_to_fixed(360, ANGLE_FRAC_BITS));
    localparam logic [PROD_W-1:0] GAIN_HALF = PROD_W'(1 << (eac_pkg::GAIN_FRAC - 1));
    localparam logic [SAT_BITS:0] CORR_SAT  = {1'b1, {SAT_BITS{1'b0}}};

    logic                  sum_neg;
    logic [SUM_WIDTH-1:0]  sum_mag;
    logic [MAG_W-1:0]      mag_ext;
    logic                  mag_big;
    logic [PROD_W-1:0]     product;
    logic [RND_W-1:0]      rounded;
    logic [SAT_BITS:0]     corr_mag;
    logic signed [DW-1:0]  correction;
    logic signed [DW-1:0]  drive_raw;
    logic signed [DW-1:0]  drive_wrap;
    logic signed [DW-1:0]  drive_sat;
    logic signed [DW-1:0]  deviation;
    logic signed [DW-1:0]  dev_wrap;

    assign sum_neg = i_sum[SUM_WIDTH-1];
    assign sum_mag = sum_neg ? $unsigned(-i_sum) : $unsigned(i_sum);
    assign mag_ext = MAG_W'(sum_mag);
    assign mag_big = (mag_ext >> MB) != '0;
    assign product = PROD_W'(mag_ext[MB-1:0]) * PROD_W'(i_gain_ki);
    assign rounded = RND_W'((product + GAIN_HALF) >> eac_pkg::GAIN_FRAC);

    always_comb begin
        if ((mag_big && (i_gain_ki != '0)) || ((rounded >> SAT_BITS) != '0)) begin
            corr_mag = CORR_SAT;
        end else begin
            corr_mag = rounded[SAT_BITS:0];
        end
    end

    assign correction = sum_neg ? -$signed(DW'(corr_mag)) : $signed(DW'(corr_mag));
    assign drive_raw  = $signed(DW'(i_command_angle)) - correction;

    always_comb begin
        drive_wrap = drive_raw;
        if (drive_raw > DEG360) begin
            drive_wrap = drive_raw - DEG360;
        end else if (drive_raw < 0) begin
            drive_wrap = drive_raw + DEG360;
        end
        drive_sat = drive_wrap;
        if (drive_wrap < 0) begin
            drive_sat = '0;
        end else if (drive_wrap > DEG360) begin
            drive_sat = DEG360;
        end
    end

    assign deviation = $signed(DW'(i_sensor_angle)) - drive_sat;

    always_comb begin
        dev_wrap = deviation;
        if (deviation > DEG180) begin
            dev_wrap = deviation - DEG360;
        end else if (deviation < -DEG180) begin
            dev_wrap = deviation + DEG360;
        end
    end

    always_comb begin
        o_bound_move.grow   = i_integral_enable && (dev_wrap > DEG90);
        o_bound_move.shrink = i_integral_enable && (dev_wrap < -DEG90);
        o_drive_angle       = i_integral_enable ? drive_sat[eac_pkg::ANGLE_W-1:0]
                                                : i_command_angle;
    end

endmodule

// ===== design/excitation_angle_corrector.sv =====
`timescale 1ns / 1ps
// excitation_angle_corrector: top level. Integral angle correction, bound
// adaptation and speed estimate. Depends on eac_pkg and eac_drive.
//
// Usage:
//   s_axis carries one angle pair per transfer; m_axis returns one result per
//   pair, in order. i_cfg_* writes one register per transfer (index, data);
//   o_cfg_ready is always high. Write registers only while no item is in
//   flight. Writing limit_start reloads the bound and clears the error sum.
//   Each accepted pair moves through the stage one, stage two and output
//   registers. Throughput: one pair per cycle unless the receiver stalls.
//   The error sum and bound form a loop: stage one clamps the next sum
//   against three candidate bounds while stage two settles the previous
//   item's bound move via the gain multiplier; the move picks among them.
//   Reset (synchronous, active low) empties the pipeline, loads register
//   defaults, loads the bound from limit_start and clears the error sum and
//   the previous sensor angle. When the receiver stalls, the output register
//   holds; the two stages behind it keep filling, then s_axis_tready drops.
module excitation_angle_corrector #(
    parameter int ANGLE_FRAC_BITS = eac_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int SUM_WIDTH       = eac_pkg::SUM_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [eac_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [eac_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [16:0] sensor_angle, [33:17] command_angle, [39:34] zero
    input  logic [eac_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [16:0] angle_error, [48:17] integrated_error, [65:49] drive_angle,
    // [97:66] speed_estimate, [103:98] zero
    output logic [eac_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int AW      = eac_pkg::angle_calc_width(ANGLE_FRAC_BITS);
    localparam int AV_W    = eac_pkg::ANGLE_W + 1;
    localparam int OW      = (SUM_WIDTH > eac_pkg::OUT_W) ? SUM_WIDTH : eac_pkg::OUT_W;
    localparam int LIM_W   = (SUM_WIDTH > eac_pkg::LIMIT_W) ? SUM_WIDTH : eac_pkg::LIMIT_W;
    localparam int SPD_P_W = eac_pkg::ANGLE_W + eac_pkg::SCALE_W;
    localparam int SPD_R_W = SPD_P_W - eac_pkg::SPEED_FRAC;

    localparam logic signed [AW-1:0] DEG180 = AW'(eac_pkg::deg_to_fixed(180, ANGLE_FRAC_BITS));
    localparam logic signed [AW-1:0] DEG360 = AW'(eac_pkg::deg_to_fixed(360, ANGLE_FRAC_BITS));
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic signed [SUM_WIDTH:0]   SUM_MAX_X = (SUM_WIDTH+1)'(SUM_MAX);
    localparam logic signed [SUM_WIDTH:0]   SUM_MIN_X = (SUM_WIDTH+1)'(SUM_MIN);
    localparam logic signed [OW-1:0] INT32_MAX_X = OW'(64'sd2147483647);
    localparam logic signed [OW-1:0] INT32_MIN_X = OW'(-64'sd2147483648);
    localparam logic [SPD_P_W-1:0] SPEED_HALF = SPD_P_W'(1 << (eac_pkg::SPEED_FRAC - 1));

    function automatic logic signed [SUM_WIDTH-1:0] bound_clamp(
        input logic signed [SUM_WIDTH-1:0] value,
        input logic signed [SUM_WIDTH-1:0] bound
    );
        logic signed [SUM_WIDTH-1:0] v;
        v = value;
        if (v >= bound) v = bound;
        if (v <= -bound) v = -bound;
        return v;
    endfunction

    function automatic logic signed [SUM_WIDTH-1:0] bound_from_limit(
        input logic [eac_pkg::LIMIT_W-1:0] limit
    );
        logic [LIM_W-1:0] wide;
        wide = LIM_W'(limit);
        if ((wide >> (SUM_WIDTH - 1)) != '0) return SUM_MAX;
        return $signed(SUM_WIDTH'(wide));
    endfunction

    // configuration
    logic                          r_integral_enable;
    logic [eac_pkg::GAIN_W-1:0]    r_gain_ki;
    logic [eac_pkg::STEP_W-1:0]    r_limit_step;
    logic [eac_pkg::SCALE_W-1:0]   r_speed_scale;
    logic                          cfg_fire;
    logic                          cfg_limit;

    // loop state
    logic signed [SUM_WIDTH-1:0]   r_err_sum;
    logic signed [SUM_WIDTH-1:0]   n_err_sum;
    logic signed [SUM_WIDTH-1:0]   r_bound;
    logic signed [SUM_WIDTH-1:0]   n_bound;
    logic [eac_pkg::ANGLE_W-1:0]   r_prev_sensor;

    // pipeline control
    logic r_v1;
    logic r_v2;
    logic r_vo;
    logic out_load;
    logic s2_out;
    logic s2_free;
    logic s1_out;
    logic s1_free;

    // stage one
    logic [eac_pkg::ANGLE_W-1:0]   r_s1_sensor;
    logic [eac_pkg::ANGLE_W-1:0]   r_s1_command;
    logic signed [AW-1:0]          s1_diff;
    logic signed [AW-1:0]          s1_fold;
    logic signed [AV_W-1:0]        s1_err;
    logic signed [SUM_WIDTH:0]     s1_sum_raw;
    logic signed [SUM_WIDTH-1:0]   s1_sum_sat;
    logic signed [SUM_WIDTH:0]     bound_up_raw;
    logic signed [SUM_WIDTH:0]     bound_dn_raw;
    logic signed [SUM_WIDTH-1:0]   bound_up;
    logic signed [SUM_WIDTH-1:0]   bound_dn;
    logic signed [SUM_WIDTH-1:0]   cand_keep;
    logic signed [SUM_WIDTH-1:0]   cand_up;
    logic signed [SUM_WIDTH-1:0]   cand_dn;
    logic signed [AW-1:0]          s1_step;
    logic signed [AW-1:0]          s1_step_wrap;

    // stage two
    logic [eac_pkg::ANGLE_W-1:0]   r_s2_sensor;
    logic [eac_pkg::ANGLE_W-1:0]   r_s2_command;
    logic [eac_pkg::ERR_W-1:0]     r_s2_err;
    logic signed [SUM_WIDTH-1:0]   r_s2_sum;
    logic signed [AV_W-1:0]        r_s2_delta;
    eac_pkg::t_bound_move          s2_move;
    logic [eac_pkg::ANGLE_W-1:0]   s2_drive;
    logic signed [OW-1:0]          s2_sum_ext;
    logic [eac_pkg::OUT_W-1:0]     s2_sum_out;
    logic                          s2_delta_neg;
    logic [eac_pkg::ANGLE_W-1:0]   s2_delta_mag;
    logic [SPD_P_W-1:0]            s2_speed_prod;
    logic [SPD_R_W-1:0]            s2_speed_mag;
    logic [eac_pkg::OUT_W-1:0]     s2_speed;

    // output register
    logic [eac_pkg::ERR_W-1:0]     r_o_err;
    logic [eac_pkg::OUT_W-1:0]     r_o_sum;
    logic [eac_pkg::ANGLE_W-1:0]   r_o_drive;
    logic [eac_pkg::OUT_W-1:0]     r_o_speed;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_limit   = cfg_fire && (i_cfg_index == eac_pkg::CFG_LIMIT_START);

    assign out_load      = !r_vo || m_axis_tready;
    assign s2_out        = r_v2 && out_load;
    assign s2_free       = !r_v2 || out_load;
    assign s1_out        = r_v1 && s2_free;
    assign s1_free       = !r_v1 || s2_free;
    assign s_axis_tready = s1_free;

    // stage one: error fold, sum, candidate clamps, sensor step
    always_comb begin
        s1_diff = $signed(AW'(r_s1_sensor)) - $signed(AW'(r_s1_command));
        s1_fold = s1_diff;
        if (s1_diff >= DEG180 || s1_diff <= -DEG180) begin
            if (s1_diff > 0) begin
                s1_fold = s1_diff - DEG360;
            end else begin
                s1_fold = s1_diff + DEG360;
            end
        end
        s1_err = s1_fold[AV_W-1:0];

        s1_sum_raw = (SUM_WIDTH+1)'(r_err_sum) + (SUM_WIDTH+1)'(s1_err);
        if (s1_sum_raw > SUM_MAX_X) begin
            s1_sum_sat = SUM_MAX;
        end else if (s1_sum_raw < SUM_MIN_X) begin
            s1_sum_sat = SUM_MIN;
        end else begin
            s1_sum_sat = s1_sum_raw[SUM_WIDTH-1:0];
        end

        bound_up_raw = (SUM_WIDTH+1)'(r_bound) + $signed((SUM_WIDTH+1)'(r_limit_step));
        bound_dn_raw = (SUM_WIDTH+1)'(r_bound) - $signed((SUM_WIDTH+1)'(r_limit_step));
        bound_up = (bound_up_raw > SUM_MAX_X) ? SUM_MAX : bound_up_raw[SUM_WIDTH-1:0];
        bound_dn = (bound_dn_raw < -SUM_MAX_X) ? -SUM_MAX : bound_dn_raw[SUM_WIDTH-1:0];

        cand_keep = bound_clamp(s1_sum_sat, r_bound);
        cand_up   = bound_clamp(s1_sum_sat, bound_up);
        cand_dn   = bound_clamp(s1_sum_sat, bound_dn);

        s1_step      = $signed(AW'(r_s1_sensor)) - $signed(AW'(r_prev_sensor));
        s1_step_wrap = s1_step;
        if (s1_step > DEG180) begin
            s1_step_wrap = s1_step - DEG360;
        end else if (s1_step < -DEG180) begin
            s1_step_wrap = s1_step + DEG360;
        end
    end

    // resolve loop state: the item leaving stage two picks the bound
    always_comb begin
        n_bound   = r_bound;
        n_err_sum = r_err_sum;
        if (cfg_limit) begin
            n_bound   = bound_from_limit(i_cfg_data);
            n_err_sum = '0;
        end else begin
            if (s2_out && s2_move.grow) begin
                n_bound = bound_up;
            end else if (s2_out && s2_move.shrink) begin
                n_bound = bound_dn;
            end
            if (s1_out) begin
                if (s2_out && s2_move.grow) begin
                    n_err_sum = cand_up;
                end else if (s2_out && s2_move.shrink) begin
                    n_err_sum = cand_dn;
                end else begin
                    n_err_sum = cand_keep;
                end
            end
        end
    end

    // stage two: drive angle, bound move, speed, output saturation
    eac_drive #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .SUM_WIDTH       (SUM_WIDTH)
    ) u_drive (
        .i_sum             (r_s2_sum),
        .i_sensor_angle    (r_s2_sensor),
        .i_command_angle   (r_s2_command),
        .i_gain_ki         (r_gain_ki),
        .i_integral_enable (r_integral_enable),
        .o_drive_angle     (s2_drive),
        .o_bound_move      (s2_move)
    );

    always_comb begin
        s2_sum_ext = OW'(r_s2_sum);
        if (s2_sum_ext > INT32_MAX_X) begin
            s2_sum_out = INT32_MAX_X[eac_pkg::OUT_W-1:0];
        end else if (s2_sum_ext < INT32_MIN_X) begin
            s2_sum_out = INT32_MIN_X[eac_pkg::OUT_W-1:0];
        end else begin
            s2_sum_out = s2_sum_ext[eac_pkg::OUT_W-1:0];
        end
    end

    assign s2_delta_neg  = r_s2_delta[AV_W-1];
    assign s2_delta_mag  = s2_delta_neg ? eac_pkg::ANGLE_W'($unsigned(-r_s2_delta))
                                        : eac_pkg::ANGLE_W'($unsigned(r_s2_delta));
    assign s2_speed_prod = SPD_P_W'(s2_delta_mag) * SPD_P_W'(r_speed_scale);
    assign s2_speed_mag  = SPD_R_W'((s2_speed_prod + SPEED_HALF) >> eac_pkg::SPEED_FRAC);
    assign s2_speed      = s2_delta_neg ? -eac_pkg::OUT_W'(s2_speed_mag)
                                        : eac_pkg::OUT_W'(s2_speed_mag);

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral_enable <= eac_pkg::INTEGRAL_ENABLE_RST;
            r_gain_ki         <= eac_pkg::GAIN_KI_RST;
            r_limit_step      <= eac_pkg::LIMIT_STEP_RST;
            r_speed_scale     <= eac_pkg::SPEED_SCALE_RST;
            r_err_sum         <= '0;
            r_bound           <= bound_from_limit(eac_pkg::LIMIT_START_RST);
            r_prev_sensor     <= '0;
            r_v1              <= 1'b0;
            r_v2              <= 1'b0;
            r_vo              <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (i_cfg_index)
                    eac_pkg::CFG_INTEGRAL_ENABLE: begin
                        r_integral_enable <= i_cfg_data[0];
                    end
                    eac_pkg::CFG_GAIN_KI: begin
                        r_gain_ki <= i_cfg_data[eac_pkg::GAIN_W-1:0];
                    end
                    eac_pkg::CFG_LIMIT_STEP: begin
                        r_limit_step <= i_cfg_data[eac_pkg::STEP_W-1:0];
                    end
                    eac_pkg::CFG_SPEED_SCALE: begin
                        r_speed_scale <= i_cfg_data[eac_pkg::SCALE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            r_err_sum <= n_err_sum;
            r_bound   <= n_bound;
            if (s1_out) begin
                r_prev_sensor <= r_s1_sensor;
            end
            if (s1_free) begin
                r_v1 <= s_axis_tvalid;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (out_load) begin
                r_vo <= r_v2;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s1_free) begin
            r_s1_sensor  <= s_axis_tdata[eac_pkg::ANGLE_W-1:0];
            r_s1_command <= s_axis_tdata[eac_pkg::IN_FIELDS_W-1:eac_pkg::ANGLE_W];
        end
        if (s1_out) begin
            r_s2_sensor  <= r_s1_sensor;
            r_s2_command <= r_s1_command;
            r_s2_err     <= s1_err[eac_pkg::ERR_W-1:0];
            r_s2_sum     <= n_err_sum;
            r_s2_delta   <= s1_step_wrap[AV_W-1:0];
        end
        if (s2_out) begin
            r_o_err   <= r_s2_err;
            r_o_sum   <= s2_sum_out;
            r_o_drive <= s2_drive;
            r_o_speed <= s2_speed;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {{(eac_pkg::OUT_TDATA_W - eac_pkg::OUT_FIELDS_W){1'b0}},
                            r_o_speed, r_o_drive, r_o_sum, r_o_err};

    a_bound_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bound <= SUM_MAX) && (r_bound >= -SUM_MAX))
        else $error("bound left its range");

    a_move_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_integral_enable |-> !(s2_move.grow || s2_move.shrink))
        else $error("bound move with integral mode off");

    a_bound_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !s2_out && !cfg_limit) |=> $stable(r_bound))
        else $error("bound changed without a stage two transfer");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted item missing from stage one");

endmodule
